// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the queue's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define PRQAW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define PRQAW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/prqaw_pkg.sv =====
`default_nettype none

package prqaw_pkg;

  localparam int unsigned WAIT_W      = 24;
  localparam int unsigned WAIT_TIME_W = 25;
  localparam int unsigned BATCH_W     = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [WAIT_W-1:0]  DEFAULT_WAIT_RST = 24'd10000;
  localparam logic [WAIT_W-1:0]  MIN_WAIT_RST     = 24'd5000;
  localparam logic [WAIT_W-1:0]  MAX_WAIT_RST     = 24'd1000000;
  localparam logic [BATCH_W-1:0] MIN_BATCH_RST    = 16'd32;
  localparam logic [BATCH_W-1:0] MAX_BATCH_RST    = 16'd64;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE  = 2'd0,
    FUNC_DEQUEUE  = 2'd1,
    FUNC_WAIT_END = 2'd2,
    FUNC_SHUTDOWN = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_DELIVER = 3'd1,
    KIND_TIMED   = 3'd2,
    KIND_UNTIMED = 3'd3,
    KIND_EXIT    = 3'd4,
    KIND_DROP    = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_WAIT = 3'd0,
    CFG_MIN_WAIT     = 3'd1,
    CFG_MAX_WAIT     = 3'd2,
    CFG_MIN_BATCH    = 3'd3,
    CFG_MAX_BATCH    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [WAIT_W-1:0]  default_wait;
    logic [WAIT_W-1:0]  min_wait;
    logic [WAIT_W-1:0]  max_wait;
    logic [BATCH_W-1:0] min_batch;
    logic [BATCH_W-1:0] max_batch;
  } cfg_t;

  typedef struct packed {
    logic  go;
    func_e func;
    logic  queues_empty;
  } wait_cmd_t;

  typedef struct packed {
    logic                   dormant;
    kind_e                  kind;
    logic [WAIT_TIME_W-1:0] wait_time;
  } wait_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/priority_request_queue_adaptive_wait.sv =====
// Channel   Handshake             Ports
// command   start_i (busy_o low)  func_i requeued_i unbatched_i tag_i
// result    done_o strobe         kind_o out_tag_o from_retry_o wake_worker_o wait_time_o
// config    cfg_we_i              cfg_addr_i cfg_wdata_i
//
// A command is taken in every cycle; busy_o stays low.
// Each command gives one result beat in the cycle after it is taken.
// Tags sit in one synchronous RAM whose registered read feeds out_tag_o, zeroed unless the beat delivers.
// Reset clears the queue pointers and counts and resets the wait flags and timer; no RAM sweep is needed.
// The result beat cannot be stalled by the receiver.
`default_nettype none

`include "assert_macros.svh"

module priority_request_queue_adaptive_wait #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output      logic                                busy_o,
  input  wire logic [1:0]                          func_i,
  input  wire logic                                requeued_i,
  input  wire logic                                unbatched_i,
  input  wire logic [TAG_BITS-1:0]                 tag_i,
  output      logic                                done_o,
  output      logic [2:0]                          kind_o,
  output      logic [TAG_BITS-1:0]                 out_tag_o,
  output      logic                                from_retry_o,
  output      logic                                wake_worker_o,
  output      logic [prqaw_pkg::WAIT_TIME_W-1:0]   wait_time_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [prqaw_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [prqaw_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW  = PtrW + 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW:0]   DepthSum = (PtrW + 1)'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QUEUE_DEPTH - 1);

  prqaw_pkg::cfg_t      cfg_q;
  prqaw_pkg::wait_cmd_t wait_cmd;
  prqaw_pkg::wait_rsp_t wait_rsp;
  prqaw_pkg::func_e     func;

  logic [PtrW-1:0] r_head_q, r_head_d, m_head_q, m_head_d;
  logic [CntW-1:0] r_cnt_q, r_cnt_d, m_cnt_q, m_cnt_d;
  logic [PtrW-1:0] sel_head, tail;
  logic [CntW-1:0] sel_cnt;
  logic [PtrW:0]   tail_sum;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [TAG_BITS-1:0] ram_rdata;

  logic                              done_q;
  prqaw_pkg::kind_e                  kind_q, kind_d;
  logic                              from_retry_q, from_retry_d;
  logic                              wake_q, wake_d;
  logic [prqaw_pkg::WAIT_TIME_W-1:0] wait_time_q, wait_time_d;

  assign busy_o = 1'b0;
  assign func   = prqaw_pkg::func_e'(func_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_wait <= prqaw_pkg::DEFAULT_WAIT_RST;
      cfg_q.min_wait     <= prqaw_pkg::MIN_WAIT_RST;
      cfg_q.max_wait     <= prqaw_pkg::MAX_WAIT_RST;
      cfg_q.min_batch    <= prqaw_pkg::MIN_BATCH_RST;
      cfg_q.max_batch    <= prqaw_pkg::MAX_BATCH_RST;
    end else if (cfg_we_i) begin
      case (prqaw_pkg::cfg_idx_e'(cfg_addr_i))
        prqaw_pkg::CFG_DEFAULT_WAIT: cfg_q.default_wait <= cfg_wdata_i;
        prqaw_pkg::CFG_MIN_WAIT:     cfg_q.min_wait     <= cfg_wdata_i;
        prqaw_pkg::CFG_MAX_WAIT:     cfg_q.max_wait     <= cfg_wdata_i;
        prqaw_pkg::CFG_MIN_BATCH:
          cfg_q.min_batch <= cfg_wdata_i[prqaw_pkg::BATCH_W-1:0];
        prqaw_pkg::CFG_MAX_BATCH:
          cfg_q.max_batch <= cfg_wdata_i[prqaw_pkg::BATCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Queue pointers and the result beat registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_head_q <= '0;
      r_cnt_q  <= '0;
      m_head_q <= '0;
      m_cnt_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      r_head_q <= r_head_d;
      r_cnt_q  <= r_cnt_d;
      m_head_q <= m_head_d;
      m_cnt_q  <= m_cnt_d;
      done_q   <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kind_q       <= kind_d;
      from_retry_q <= from_retry_d;
      wake_q       <= wake_d;
      wait_time_q  <= wait_time_d;
    end
  end

  always_comb begin
    sel_head = requeued_i ? r_head_q : m_head_q;
    sel_cnt  = requeued_i ? r_cnt_q : m_cnt_q;
    tail_sum = {1'b0, sel_head} + (PtrW + 1)'(sel_cnt);
    tail     = (tail_sum >= DepthSum) ? PtrW'(tail_sum - DepthSum) : tail_sum[PtrW-1:0];

    r_head_d     = r_head_q;
    r_cnt_d      = r_cnt_q;
    m_head_d     = m_head_q;
    m_cnt_d      = m_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = {requeued_i, tail};
    ram_re       = 1'b0;
    ram_raddr    = {1'b1, r_head_q};
    kind_d       = prqaw_pkg::KIND_ACK;
    from_retry_d = 1'b0;
    wake_d       = 1'b0;
    wait_time_d  = '0;

    wait_cmd.go           = start_i;
    wait_cmd.func         = func;
    wait_cmd.queues_empty = (r_cnt_q == '0) && (m_cnt_q == '0);

    if (start_i) begin
      case (func)
        prqaw_pkg::FUNC_ENQUEUE: begin
          if (sel_cnt == DepthCnt) begin
            kind_d = prqaw_pkg::KIND_DROP;
          end else begin
            ram_we = 1'b1;
            wake_d = wait_rsp.dormant || unbatched_i;
            if (requeued_i) begin
              r_cnt_d = r_cnt_q + 1'b1;
            end else begin
              m_cnt_d = m_cnt_q + 1'b1;
            end
          end
        end
        prqaw_pkg::FUNC_DEQUEUE: begin
          // The retry queue always wins; the tag arrives from the RAM next cycle.
          if (r_cnt_q != '0) begin
            ram_re       = 1'b1;
            kind_d       = prqaw_pkg::KIND_DELIVER;
            from_retry_d = 1'b1;
            r_head_d     = (r_head_q == LastPtr) ? '0 : r_head_q + 1'b1;
            r_cnt_d      = r_cnt_q - 1'b1;
          end else if (m_cnt_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = {1'b0, m_head_q};
            kind_d    = prqaw_pkg::KIND_DELIVER;
            m_head_d  = (m_head_q == LastPtr) ? '0 : m_head_q + 1'b1;
            m_cnt_d   = m_cnt_q - 1'b1;
          end else begin
            kind_d      = wait_rsp.kind;
            wait_time_d = wait_rsp.wait_time;
          end
        end
        prqaw_pkg::FUNC_WAIT_END: begin
          kind_d = prqaw_pkg::KIND_ACK;
        end
        prqaw_pkg::FUNC_SHUTDOWN: begin
          wake_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  prqaw_tag_ram #(
    .ADDR_W (AddrW),
    .DATA_W (TAG_BITS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  prqaw_wait_ctrl u_wait_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (wait_cmd),
    .rsp_o  (wait_rsp)
  );

  assign done_o        = done_q;
  assign kind_o        = kind_q;
  assign out_tag_o     = (kind_q == prqaw_pkg::KIND_DELIVER) ? ram_rdata : '0;
  assign from_retry_o  = from_retry_q;
  assign wake_worker_o = wake_q;
  assign wait_time_o   = wait_time_q;

  `PRQAW_ASSERT(a_count_bound, clk_i, rst_ni, (r_cnt_q <= DepthCnt) && (m_cnt_q <= DepthCnt), "queue count beyond depth")
  `PRQAW_ASSERT_NEXT(a_one_beat, clk_i, rst_ni, start_i, done_o, "accepted command gave no result beat")
  `PRQAW_ASSERT(a_deliver_read, clk_i, rst_ni, (done_o && kind_q == prqaw_pkg::KIND_DELIVER) |-> $past(ram_re), "delivered tag without a RAM read")
  `PRQAW_ASSERT(a_wait_only_timed, clk_i, rst_ni, (done_o && wait_time_o != '0) |-> (kind_q == prqaw_pkg::KIND_TIMED && !wait_time_o[prqaw_pkg::WAIT_TIME_W-1]), "wait time on a non-timed beat or out of range")

endmodule

`default_nettype wire

// ===== hdl/prqaw_tag_ram.sv =====
`default_nettype none

module prqaw_tag_ram #(
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned Entries = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [Entries];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/prqaw_wait_ctrl.sv =====
`default_nettype none

module prqaw_wait_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire prqaw_pkg::cfg_t      cfg_i,
  input  wire prqaw_pkg::wait_cmd_t cmd_i,
  output      prqaw_pkg::wait_rsp_t rsp_o
);

  logic [prqaw_pkg::BATCH_W-1:0]     batch_q, batch_d, batch_inc;
  logic [prqaw_pkg::WAIT_TIME_W-1:0] wait_q, wait_d, delta, grown_sat, adj;
  logic [prqaw_pkg::WAIT_TIME_W:0]   grown;
  logic                              dormant_q, dormant_d;
  logic                              alive_q, alive_d;
  logic                              untimed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q   <= '0;
      wait_q    <= {1'b0, prqaw_pkg::DEFAULT_WAIT_RST};
      dormant_q <= 1'b0;
      alive_q   <= 1'b1;
    end else begin
      batch_q   <= batch_d;
      wait_q    <= wait_d;
      dormant_q <= dormant_d;
      alive_q   <= alive_d;
    end
  end

  always_comb begin
    batch_inc = (batch_q == '1) ? batch_q : batch_q + 1'b1;
    delta     = {2'b00, wait_q[prqaw_pkg::WAIT_TIME_W-1:2]};
    grown     = {1'b0, wait_q} + {1'b0, delta};
    grown_sat = grown[prqaw_pkg::WAIT_TIME_W] ? '1 : grown[prqaw_pkg::WAIT_TIME_W-1:0];

    // The wait moves by a quarter before it is clamped.
    if (batch_inc < cfg_i.min_batch) begin
      adj = grown_sat;
    end else if (batch_inc > cfg_i.max_batch) begin
      adj = wait_q - delta;
    end else begin
      adj = wait_q;
    end

    batch_d   = batch_q;
    wait_d    = wait_q;
    dormant_d = dormant_q;
    alive_d   = alive_q;
    untimed   = 1'b0;

    if (cmd_i.go) begin
      case (cmd_i.func)
        prqaw_pkg::FUNC_WAIT_END: begin
          dormant_d = 1'b0;
          wait_d    = {1'b0, cfg_i.default_wait};
        end
        prqaw_pkg::FUNC_SHUTDOWN: begin
          alive_d = 1'b0;
        end
        prqaw_pkg::FUNC_DEQUEUE: begin
          batch_d = batch_inc;
          if (cmd_i.queues_empty && alive_q) begin
            batch_d = '0;
            if (adj >= {1'b0, cfg_i.max_wait}) begin
              if (dormant_q) begin
                wait_d  = {1'b0, cfg_i.default_wait};
                untimed = 1'b1;
              end else begin
                wait_d    = {1'b0, cfg_i.max_wait};
                dormant_d = 1'b1;
              end
            end else if (adj < {1'b0, cfg_i.min_wait}) begin
              wait_d = {1'b0, cfg_i.min_wait};
            end else begin
              wait_d = adj;
            end
          end
        end
        default: begin
        end
      endcase
    end

    rsp_o.dormant = dormant_q;
    if (!alive_q) begin
      rsp_o.kind      = prqaw_pkg::KIND_EXIT;
      rsp_o.wait_time = '0;
    end else if (untimed) begin
      rsp_o.kind      = prqaw_pkg::KIND_UNTIMED;
      rsp_o.wait_time = '0;
    end else begin
      rsp_o.kind      = prqaw_pkg::KIND_TIMED;
      rsp_o.wait_time = wait_d;
    end
  end

endmodule

`default_nettype wire

// ===== dv/priority_request_queue_adaptive_wait_test.sv =====
module priority_request_queue_adaptive_wait_test;

  localparam int unsigned QDEPTH        = 16;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned MAIN_Q        = 0;
  localparam int unsigned RETRY_Q       = 1;
  localparam int unsigned CFG_REGS      = 5;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned ROW_COUNT     = 20;
  localparam int unsigned SHUTDOWN_ROW  = 12;
  localparam logic [prqaw_pkg::WAIT_TIME_W-1:0] WAIT_SAT = '1;

  typedef struct packed {
    prqaw_pkg::kind_e                  kind;
    logic [TAG_W-1:0]                  tag;
    logic                              from_retry;
    logic                              wake;
    logic [prqaw_pkg::WAIT_TIME_W-1:0] wait_time;
  } beat_t;

  typedef struct {
    prqaw_pkg::func_e func;
    logic             requeued;
    logic             unbatched;
    logic [TAG_W-1:0] tag;
    logic             typed;
    beat_t            want;
  } row_t;

  logic                              clk_i;
  logic                              rst_ni      = 1'b0;
  logic                              start_i     = 1'b0;
  logic [1:0]                        func_i      = prqaw_pkg::FUNC_ENQUEUE;
  logic                              requeued_i  = 1'b0;
  logic                              unbatched_i = 1'b0;
  logic [TAG_W-1:0]                  tag_i       = '0;
  logic                              cfg_we_i    = 1'b0;
  logic [prqaw_pkg::CFG_IDX_W-1:0]   cfg_addr_i  = prqaw_pkg::CFG_DEFAULT_WAIT;
  logic [prqaw_pkg::CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                              busy_o;
  logic                              done_o;
  logic [2:0]                        kind_o;
  logic [TAG_W-1:0]                  out_tag_o;
  logic                              from_retry_o;
  logic                              wake_worker_o;
  logic [prqaw_pkg::WAIT_TIME_W-1:0] wait_time_o;

  // Expectation typed into a script row travels alongside the command.
  logic  typed_on   = 1'b0;
  beat_t typed_beat = '0;

  priority_request_queue_adaptive_wait uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Shadow copy of the queues, the wait timer and the registers.
  logic [prqaw_pkg::WAIT_W-1:0]      default_wait = prqaw_pkg::DEFAULT_WAIT_RST;
  logic [prqaw_pkg::WAIT_W-1:0]      min_wait     = prqaw_pkg::MIN_WAIT_RST;
  logic [prqaw_pkg::WAIT_W-1:0]      max_wait     = prqaw_pkg::MAX_WAIT_RST;
  logic [prqaw_pkg::BATCH_W-1:0]     min_batch    = prqaw_pkg::MIN_BATCH_RST;
  logic [prqaw_pkg::BATCH_W-1:0]     max_batch    = prqaw_pkg::MAX_BATCH_RST;
  logic [TAG_W-1:0]                  slot_mem [2][QDEPTH];
  logic [3:0]                        q_head [2]   = '{4'd0, 4'd0};
  logic [4:0]                        q_count [2]  = '{5'd0, 5'd0};
  logic [prqaw_pkg::BATCH_W-1:0]     batch_cnt    = '0;
  logic [prqaw_pkg::WAIT_TIME_W-1:0] wait_val     =
      prqaw_pkg::WAIT_TIME_W'(prqaw_pkg::DEFAULT_WAIT_RST);
  logic                              dormant      = 1'b0;
  logic                              alive        = 1'b1;

  beat_t       pending_results [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_pct   = 0;
  int unsigned cycle_cnt  = 0;
  row_t        script [ROW_COUNT];

  function automatic beat_t serve_command(input prqaw_pkg::func_e f, input logic rq,
                                          input logic ub, input logic [TAG_W-1:0] t);
    beat_t                             r;
    int unsigned                       q;
    logic [prqaw_pkg::WAIT_TIME_W:0]   grown;
    logic [prqaw_pkg::WAIT_TIME_W-1:0] quarter;
    r = '0;
    case (f)
      prqaw_pkg::FUNC_ENQUEUE: begin
        q = rq ? RETRY_Q : MAIN_Q;
        if (q_count[q] == 5'(QDEPTH)) begin
          r.kind = prqaw_pkg::KIND_DROP;
        end else begin
          slot_mem[q][4'(q_head[q] + q_count[q])] = t;
          q_count[q]++;
          r.kind = prqaw_pkg::KIND_ACK;
          r.wake = dormant | ub;
        end
      end
      prqaw_pkg::FUNC_WAIT_END: begin
        dormant  = 1'b0;
        wait_val = prqaw_pkg::WAIT_TIME_W'(default_wait);
        r.kind   = prqaw_pkg::KIND_ACK;
      end
      prqaw_pkg::FUNC_SHUTDOWN: begin
        alive  = 1'b0;
        r.kind = prqaw_pkg::KIND_ACK;
        r.wake = 1'b1;
      end
      default: begin
        if (batch_cnt != '1) batch_cnt++;
        if (q_count[RETRY_Q] != 0 || q_count[MAIN_Q] != 0) begin
          q = (q_count[RETRY_Q] != 0) ? RETRY_Q : MAIN_Q;
          r.kind       = prqaw_pkg::KIND_DELIVER;
          r.tag        = slot_mem[q][q_head[q]];
          r.from_retry = (q == RETRY_Q);
          q_head[q]++;
          q_count[q]--;
        end else if (!alive) begin
          r.kind = prqaw_pkg::KIND_EXIT;
        end else begin
          // The wait moves by a quarter first, and only then is clamped.
          quarter = wait_val >> 2;
          if (batch_cnt < min_batch) begin
            grown    = {1'b0, wait_val} + {1'b0, quarter};
            wait_val = (grown > {1'b0, WAIT_SAT}) ? WAIT_SAT
                                                  : grown[prqaw_pkg::WAIT_TIME_W-1:0];
          end else if (batch_cnt > max_batch) begin
            wait_val = wait_val - quarter;
          end
          batch_cnt = '0;
          r.kind    = prqaw_pkg::KIND_TIMED;
          if (wait_val >= prqaw_pkg::WAIT_TIME_W'(max_wait)) begin
            if (dormant) begin
              wait_val = prqaw_pkg::WAIT_TIME_W'(default_wait);
              r.kind   = prqaw_pkg::KIND_UNTIMED;
            end else begin
              wait_val = prqaw_pkg::WAIT_TIME_W'(max_wait);
              dormant  = 1'b1;
            end
          end else if (wait_val < prqaw_pkg::WAIT_TIME_W'(min_wait)) begin
            wait_val = prqaw_pkg::WAIT_TIME_W'(min_wait);
          end
          if (r.kind == prqaw_pkg::KIND_TIMED) r.wait_time = wait_val;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void take_config(input logic [prqaw_pkg::CFG_IDX_W-1:0] addr,
                                      input logic [prqaw_pkg::CFG_DATA_W-1:0] data);
    case (addr)
      prqaw_pkg::CFG_DEFAULT_WAIT: default_wait = data;
      prqaw_pkg::CFG_MIN_WAIT:     min_wait     = data;
      prqaw_pkg::CFG_MAX_WAIT:     max_wait     = data;
      prqaw_pkg::CFG_MIN_BATCH:    min_batch    = data[prqaw_pkg::BATCH_W-1:0];
      prqaw_pkg::CFG_MAX_BATCH:    max_batch    = data[prqaw_pkg::BATCH_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    beat_t want;
    if (rst_ni) begin
      if (cfg_we_i) take_config(cfg_addr_i, cfg_wdata_i);
      if (start_i && !busy_o) begin
        want = serve_command(prqaw_pkg::func_e'(func_i), requeued_i, unbatched_i, tag_i);
        if (typed_on) want = typed_beat;
        pending_results.push_back(want);
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding, kind %0d", kind_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("out_tag", 32'(want.tag), 32'(out_tag_o));
          check_field("from_retry", 32'(want.from_retry), 32'(from_retry_o));
          check_field("wake_worker", 32'(want.wake), 32'(wake_worker_o));
          check_field("wait_time", 32'(want.wait_time), 32'(wait_time_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("priority_request_queue_adaptive_wait_test: errors");
      $finish;
    end
  end

  // Every stimulus task starts and ends at a falling edge.
  task automatic send(input prqaw_pkg::func_e f, input logic rq, input logic ub,
                      input logic [TAG_W-1:0] t, input logic typed = 1'b0,
                      input beat_t want = '0);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    func_i      <= f;
    requeued_i  <= rq;
    unbatched_i <= ub;
    tag_i       <= t;
    typed_on    <= typed;
    typed_beat  <= want;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic send_random(input prqaw_pkg::func_e f);
    send(f, 1'($urandom), 1'($urandom), TAG_W'($urandom));
  endtask

  task automatic drain();
    while (q_count[MAIN_Q] + q_count[RETRY_Q] != 0) send_random(prqaw_pkg::FUNC_DEQUEUE);
  endtask

  // Sends a burst of enqueues to one queue; tags beyond its free slots are dropped.
  task automatic fill_burst();
    logic rq;
    rq = 1'($urandom);
    repeat ($urandom_range(QDEPTH - 1, QDEPTH + 4))
      send(prqaw_pkg::FUNC_ENQUEUE, rq, 1'($urandom), TAG_W'($urandom));
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [prqaw_pkg::CFG_IDX_W-1:0] addr,
                           input logic [prqaw_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic program_cfg(input logic [prqaw_pkg::WAIT_W-1:0] dw,
                             input logic [prqaw_pkg::WAIT_W-1:0] minw,
                             input logic [prqaw_pkg::WAIT_W-1:0] maxw,
                             input logic [prqaw_pkg::BATCH_W-1:0] minb,
                             input logic [prqaw_pkg::BATCH_W-1:0] maxb);
    settle();
    write_reg(prqaw_pkg::CFG_IDX_W'($urandom_range(CFG_REGS, (1 << prqaw_pkg::CFG_IDX_W) - 1)),
              prqaw_pkg::CFG_DATA_W'($urandom));
    write_reg(prqaw_pkg::CFG_DEFAULT_WAIT, dw);
    write_reg(prqaw_pkg::CFG_MIN_WAIT, minw);
    write_reg(prqaw_pkg::CFG_MAX_WAIT, maxw);
    // Spare upper data bits must be ignored by the batch registers.
    write_reg(prqaw_pkg::CFG_MIN_BATCH, {8'($urandom), minb});
    write_reg(prqaw_pkg::CFG_MAX_BATCH, {8'($urandom), maxb});
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_rows(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i <= hi; i++)
      send(script[i].func, script[i].requeued, script[i].unbatched, script[i].tag,
           script[i].typed, script[i].want);
  endtask

  task automatic run_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 6)) send_random(prqaw_pkg::FUNC_ENQUEUE);
    end else if (pick < 60) begin
      repeat ($urandom_range(1, 8)) send_random(prqaw_pkg::FUNC_DEQUEUE);
    end else if (pick < 70) begin
      fill_burst();
    end else if (pick < 85) begin
      // Empty the queues, then let the worker find nothing and go to wait.
      drain();
      repeat ($urandom_range(1, 6)) send_random(prqaw_pkg::FUNC_DEQUEUE);
      if (dormant && $urandom_range(0, 1) == 1) send_random(prqaw_pkg::FUNC_WAIT_END);
    end else if (pick < 93) begin
      send_random(prqaw_pkg::FUNC_WAIT_END);
    end else begin
      send_random(prqaw_pkg::func_e'($urandom_range(prqaw_pkg::FUNC_ENQUEUE,
                                                    prqaw_pkg::FUNC_WAIT_END)));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned p;
    script = '{
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b0, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_TIMED, 16'h0, 1'b0, 1'b0, 25'd12500}},
      '{prqaw_pkg::FUNC_ENQUEUE,  1'b0, 1'b0, 16'hFFFF, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_ENQUEUE,  1'b1, 1'b1, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b1, 25'd0}},
      '{prqaw_pkg::FUNC_ENQUEUE,  1'b0, 1'b1, 16'h8001, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b1, 25'd0}},
      '{prqaw_pkg::FUNC_ENQUEUE,  1'b1, 1'b0, 16'h7FFE, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b1, 1'b1, 16'hFFFF, 1'b1,
        '{prqaw_pkg::KIND_DELIVER, 16'h0000, 1'b1, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b0, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_DELIVER, 16'h7FFE, 1'b1, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b1, 16'h5555, 1'b1,
        '{prqaw_pkg::KIND_DELIVER, 16'hFFFF, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b1, 1'b0, 16'hAAAA, 1'b1,
        '{prqaw_pkg::KIND_DELIVER, 16'h8001, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b0, 16'h0000, 1'b0, '0},
      '{prqaw_pkg::FUNC_WAIT_END, 1'b1, 1'b1, 16'hFFFF, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b0, 16'h0000, 1'b0, '0},
      // Shutdown rows run after the random phases, as nothing brings the worker back to life.
      '{prqaw_pkg::FUNC_SHUTDOWN, 1'b0, 1'b0, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b1, 25'd0}},
      '{prqaw_pkg::FUNC_SHUTDOWN, 1'b1, 1'b1, 16'hFFFF, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b1, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b0, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_EXIT, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_WAIT_END, 1'b0, 1'b1, 16'h1234, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_ENQUEUE,  1'b1, 1'b0, 16'h1357, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b0, 1'b0, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_DELIVER, 16'h1357, 1'b1, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_DEQUEUE,  1'b1, 1'b1, 16'hFFFF, 1'b1,
        '{prqaw_pkg::KIND_EXIT, 16'h0, 1'b0, 1'b0, 25'd0}},
      '{prqaw_pkg::FUNC_ENQUEUE,  1'b0, 1'b1, 16'h0000, 1'b1,
        '{prqaw_pkg::KIND_ACK, 16'h0, 1'b0, 1'b1, 25'd0}}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 38;
    run_rows(0, SHUTDOWN_ROW - 1);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: program_cfg(24'd100, 24'd50, 24'd200, 16'd4, 16'd8);
        1: program_cfg('1, '1, '1, '1, '1);
        2: program_cfg('0, '0, '0, '0, '0);
        3: program_cfg(24'($urandom_range(0, 4000)), 24'($urandom_range(0, 2000)),
                       24'($urandom_range(2000, 30000)), 16'($urandom_range(0, 6)),
                       16'($urandom_range(2, 12)));
        4: program_cfg(24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
                       16'($urandom));
        default: program_cfg(prqaw_pkg::DEFAULT_WAIT_RST, prqaw_pkg::MIN_WAIT_RST,
                             prqaw_pkg::MAX_WAIT_RST, prqaw_pkg::MIN_BATCH_RST,
                             prqaw_pkg::MAX_BATCH_RST);
      endcase
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 82;
        default: idle_pct = 38;
      endcase
      fill_burst();
      phase_end = beats_sent + PHASE_ITEMS;
      while (beats_sent < phase_end) run_sequence();
    end

    idle_pct = 38;
    drain();
    run_rows(SHUTDOWN_ROW, ROW_COUNT - 1);
    repeat (40) send_random(prqaw_pkg::func_e'($urandom_range(prqaw_pkg::FUNC_ENQUEUE,
                                                              prqaw_pkg::FUNC_SHUTDOWN)));

    settle();
    if (mismatches == 0)
      $display("priority_request_queue_adaptive_wait_test: clean");
    else
      $display("priority_request_queue_adaptive_wait_test: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/prqaw_pkg.sv
hdl/prqaw_tag_ram.sv
hdl/prqaw_wait_ctrl.sv
hdl/priority_request_queue_adaptive_wait.sv
dv/priority_request_queue_adaptive_wait_test.sv
